// File: rtl/auto_exposure_stepper_core_assert.svh
// assertion helpers for the exposure stepper core
`ifndef AUTO_EXPOSURE_STEPPER_CORE_ASSERT_SVH
`define AUTO_EXPOSURE_STEPPER_CORE_ASSERT_SVH

// same-cycle implication, checked out of reset
`define AESC_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define AESC_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/aes_pkg.sv
`timescale 1ns / 1ps
package aes_pkg;

    localparam int CHANNEL_BITS = 8;
    localparam int COUNT_BITS   = 28;
    localparam int SUM_BITS     = CHANNEL_BITS + COUNT_BITS;
    localparam int EXP_BITS     = 16;
    localparam int LIMIT_BITS   = 8;
    localparam int CFG_IDX_BITS = 3;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    // item kinds carried on s_tuser
    localparam logic OP_PIXEL  = 1'b0;
    localparam logic OP_ADJUST = 1'b1;

    // register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_ADJUST_STEP      = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_EXPOSURE_FLOOR   = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_EXPOSURE_CEILING = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_BRIGHT_LIMIT     = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_DARK_LIMIT       = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_EXPOSURE_START   = 3'd5;

    // register reset values
    localparam logic [EXP_BITS-1:0]   RST_ADJUST_STEP      = 16'd1;
    localparam logic [EXP_BITS-1:0]   RST_EXPOSURE_FLOOR   = 16'd0;
    localparam logic [EXP_BITS-1:0]   RST_EXPOSURE_CEILING = 16'd65535;
    localparam logic [LIMIT_BITS-1:0] RST_BRIGHT_LIMIT     = 8'd160;
    localparam logic [LIMIT_BITS-1:0] RST_DARK_LIMIT       = 8'd96;
    localparam logic [EXP_BITS-1:0]   RST_EXPOSURE_START   = 16'd1000;

    // adjust decision handed from the compare stage to the exposure stage
    typedef struct packed {
        logic bright;
        logic dark;
    } decision_t;

endpackage

// File: rtl/auto_exposure_stepper_core.sv
`timescale 1ns / 1ps
// an adjust item's result reaches m_tvalid through the input, compare and output registers
// throughput: one item per cycle, pixels and adjusts alike; the only stall is a held result
// pipeline: input register, compare register (max sum vs limit*count), output register
// reset (aresetn low, synchronous): sums and count cleared, restart pending,
// registers at their defaults, exposure loaded with exposure_start, all stages empty
module auto_exposure_stepper_core
    import aes_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,

    // input stream
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [23:0]             s_tdata,   // [7:0] chan_blue, [15:8] chan_green,
                                               // [23:16] chan_red
    input  logic                    s_tuser,   // [0] op

    // result stream
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [23:0]             m_tdata,   // [15:0] exposure_value, [16] changed,
                                               // [23:17] zero

    // register write channel
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CFG_IDX_BITS-1:0] cfg_index,
    input  logic [EXP_BITS-1:0]     cfg_data
);

`include "auto_exposure_stepper_core_assert.svh"

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [EXP_BITS-1:0]   adjust_step_reg;
    logic [EXP_BITS-1:0]   exposure_floor_reg;
    logic [EXP_BITS-1:0]   exposure_ceiling_reg;
    logic [LIMIT_BITS-1:0] bright_limit_reg;
    logic [LIMIT_BITS-1:0] dark_limit_reg;
    logic                  cfg_fire;

    // ------------------------------------------------------------------
    // pipeline registers
    // ------------------------------------------------------------------
    // input stage
    logic                    in_valid_reg;
    logic                    in_op_reg;
    logic [CHANNEL_BITS-1:0] in_blue_reg;
    logic [CHANNEL_BITS-1:0] in_green_reg;
    logic [CHANNEL_BITS-1:0] in_red_reg;

    // accumulation state
    logic [SUM_BITS-1:0]     sum_blue_reg;
    logic [SUM_BITS-1:0]     sum_green_reg;
    logic [SUM_BITS-1:0]     sum_red_reg;
    logic [COUNT_BITS-1:0]   pixel_count_reg;
    logic                    restart_pending_reg;

    // decision stage
    logic                    dec_valid_reg;
    decision_t               dec_reg;
    decision_t               dec_next;

    // exposure and output stage
    logic [EXP_BITS-1:0]     exposure_reg;
    logic [EXP_BITS-1:0]     exposure_next;
    logic                    changed_next;
    logic                    m_valid_reg;
    logic [EXP_BITS-1:0]     m_exposure_reg;
    logic                    m_changed_reg;

    // ------------------------------------------------------------------
    // flow control: pixels retire in the input stage, adjusts move on
    // ------------------------------------------------------------------
    logic out_free;
    logic dec_adv;
    logic in_is_pixel;
    logic in_adv;
    logic s_fire;

    assign out_free    = !m_valid_reg || m_tready;
    assign dec_adv     = !dec_valid_reg || out_free;
    assign in_is_pixel = (in_op_reg == OP_PIXEL);
    // the input stage empties when its item retires this cycle
    assign in_adv      = !in_valid_reg || in_is_pixel || dec_adv;
    assign s_tready    = in_adv;
    assign s_fire      = s_tvalid && s_tready;

    assign cfg_ready   = 1'b1;
    assign cfg_fire    = cfg_valid && cfg_ready;

    // ------------------------------------------------------------------
    // compare logic: brightest channel sum against limit * count
    // ------------------------------------------------------------------
    logic [SUM_BITS-1:0] peak_bg;
    logic [SUM_BITS-1:0] peak;
    logic [SUM_BITS-1:0] bright_bound;
    logic [SUM_BITS-1:0] dark_bound;

    always_comb begin
        peak_bg      = (sum_green_reg > sum_blue_reg) ? sum_green_reg : sum_blue_reg;
        peak         = (sum_red_reg > peak_bg) ? sum_red_reg : peak_bg;
        // 8 x 28 products fit the sum width exactly
        bright_bound = SUM_BITS'(bright_limit_reg) * SUM_BITS'(pixel_count_reg);
        dark_bound   = SUM_BITS'(dark_limit_reg) * SUM_BITS'(pixel_count_reg);
        dec_next.bright = (peak > bright_bound);
        dec_next.dark   = !dec_next.bright && (peak < dark_bound);
    end

    // ------------------------------------------------------------------
    // exposure step with clamping
    // ------------------------------------------------------------------
    logic [EXP_BITS-1:0] exp_down;
    logic [EXP_BITS:0]   exp_up;

    always_comb begin
        exp_down      = exposure_reg - adjust_step_reg;
        exp_up        = {1'b0, exposure_reg} + {1'b0, adjust_step_reg};
        exposure_next = exposure_reg;
        changed_next  = 1'b0;
        if (dec_reg.bright) begin
            // stepping down checks the floor only, also on underflow
            if (adjust_step_reg > exposure_reg || exp_down < exposure_floor_reg) begin
                exposure_next = exposure_floor_reg;
            end else begin
                exposure_next = exp_down;
            end
            changed_next = 1'b1;
        end else if (dec_reg.dark) begin
            // full-width sum so a large step never wraps past the ceiling
            if (exp_up > {1'b0, exposure_ceiling_reg}) begin
                exposure_next = exposure_ceiling_reg;
            end else begin
                exposure_next = exp_up[EXP_BITS-1:0];
            end
            changed_next = 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // input stage
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (in_adv) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_op_reg    <= s_tuser;
            in_blue_reg  <= s_tdata[7:0];
            in_green_reg <= s_tdata[15:8];
            in_red_reg   <= s_tdata[23:16];
        end
    end

    // ------------------------------------------------------------------
    // accumulation: first pixel after an adjust restarts the run,
    // a full count freezes the sums until the next restart
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_blue_reg        <= '0;
            sum_green_reg       <= '0;
            sum_red_reg         <= '0;
            pixel_count_reg     <= '0;
            restart_pending_reg <= 1'b1;
        end else if (in_valid_reg) begin
            if (in_is_pixel) begin
                if (restart_pending_reg) begin
                    sum_blue_reg        <= SUM_BITS'(in_blue_reg);
                    sum_green_reg       <= SUM_BITS'(in_green_reg);
                    sum_red_reg         <= SUM_BITS'(in_red_reg);
                    pixel_count_reg     <= COUNT_BITS'(1);
                    restart_pending_reg <= 1'b0;
                end else if (pixel_count_reg < COUNT_MAX) begin
                    sum_blue_reg    <= sum_blue_reg + SUM_BITS'(in_blue_reg);
                    sum_green_reg   <= sum_green_reg + SUM_BITS'(in_green_reg);
                    sum_red_reg     <= sum_red_reg + SUM_BITS'(in_red_reg);
                    pixel_count_reg <= pixel_count_reg + COUNT_BITS'(1);
                end
            end else if (dec_adv) begin
                // adjust leaves the sums for a repeated compare
                restart_pending_reg <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // decision stage
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dec_valid_reg <= 1'b0;
        end else if (dec_adv) begin
            dec_valid_reg <= in_valid_reg && !in_is_pixel;
        end
    end

    always_ff @(posedge aclk) begin
        if (dec_adv && in_valid_reg && !in_is_pixel) begin
            dec_reg <= dec_next;
        end
    end

    // ------------------------------------------------------------------
    // exposure state and output register
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            exposure_reg <= RST_EXPOSURE_START;
            m_valid_reg  <= 1'b0;
        end else begin
            if (dec_valid_reg && out_free) begin
                exposure_reg <= exposure_next;
                m_valid_reg  <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg  <= 1'b0;
            end
            // start value reloads the exposure; the user must write it only while idle, the block does not enforce this
            if (cfg_fire && cfg_index == REG_EXPOSURE_START) begin
                exposure_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (dec_valid_reg && out_free) begin
            m_exposure_reg <= exposure_next;
            m_changed_reg  <= changed_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'd0, m_changed_reg, m_exposure_reg};

    // ------------------------------------------------------------------
    // register writes; unknown indexes are dropped
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            adjust_step_reg      <= RST_ADJUST_STEP;
            exposure_floor_reg   <= RST_EXPOSURE_FLOOR;
            exposure_ceiling_reg <= RST_EXPOSURE_CEILING;
            bright_limit_reg     <= RST_BRIGHT_LIMIT;
            dark_limit_reg       <= RST_DARK_LIMIT;
        end else if (cfg_fire) begin
            case (cfg_index)
                REG_ADJUST_STEP:      adjust_step_reg      <= cfg_data;
                REG_EXPOSURE_FLOOR:   exposure_floor_reg   <= cfg_data;
                REG_EXPOSURE_CEILING: exposure_ceiling_reg <= cfg_data;
                REG_BRIGHT_LIMIT:     bright_limit_reg     <= cfg_data[LIMIT_BITS-1:0];
                REG_DARK_LIMIT:       dark_limit_reg       <= cfg_data[LIMIT_BITS-1:0];
                REG_EXPOSURE_START: begin
                    // the start value goes straight into the live exposure
                end
                default: begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    // an empty run never carries sums
    `AESC_ASSERT_NOW(a_empty_run_zero, aclk, aresetn, pixel_count_reg == '0, sum_blue_reg == '0 && sum_green_reg == '0 && sum_red_reg == '0, "sums nonzero with zero count")
    // bright and dark are exclusive
    `AESC_ASSERT_NOW(a_dec_exclusive, aclk, aresetn, dec_valid_reg, !(dec_reg.bright && dec_reg.dark), "bright and dark both set")
    // a decision blocked by a held result waits unchanged
    `AESC_ASSERT_NXT(a_dec_holds, aclk, aresetn, dec_valid_reg && !dec_adv, dec_valid_reg && $stable(dec_reg), "decision lost while stalled")

endmodule
